// ===== rtl/expression_tokenizer_top_macros.svh =====
// Assertion macros for the expression tokenizer RTL.
// Included by etl_queue, the module that carries concurrent assertions; no dependencies.
`ifndef EXPRESSION_TOKENIZER_TOP_MACROS_SVH
`define EXPRESSION_TOKENIZER_TOP_MACROS_SVH

// Check cons in the same cycle as ante, outside reset.
`define ETL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("expression tokenizer assertion failed");

// Check cons in the cycle after ante, outside reset.
`define ETL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("expression tokenizer assertion failed");

`endif

// ===== rtl/etl_pkg.sv =====
// Shared types and constants of the expression tokenizer.
// No dependencies; imported by every module of the block.
package etl_pkg;

  localparam logic [2:0] KIND_NUMBER   = 3'd0;
  localparam logic [2:0] KIND_IDENT    = 3'd1;
  localparam logic [2:0] KIND_OPERATOR = 3'd2;
  localparam logic [2:0] KIND_LPAREN   = 3'd3;
  localparam logic [2:0] KIND_RPAREN   = 3'd4;
  localparam logic [2:0] KIND_COMMA    = 3'd5;
  localparam logic [2:0] KIND_END      = 3'd6;
  localparam logic [2:0] KIND_INVALID  = 3'd7;

  localparam logic [2:0] MODE_IDLE       = 3'd0;
  localparam logic [2:0] MODE_IDENT      = 3'd1;
  localparam logic [2:0] MODE_INT        = 3'd2;
  localparam logic [2:0] MODE_FRAC       = 3'd3;
  localparam logic [2:0] MODE_EXP_START  = 3'd4;
  localparam logic [2:0] MODE_EXP_DIGITS = 3'd5;

  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_E_LO   = 8'h65;
  localparam logic [7:0] CH_E_UP   = 8'h45;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_GREAT  = 8'h3E;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic digit;
    logic alpha;
    logic under;
    logic space;
    logic oper;
    logic lparen;
    logic rparen;
    logic comma;
    logic dot;
    logic exp;
    logic minus;
  } char_class_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [7:0]  symbol;
    logic        last;
  } token_t;

endpackage

// ===== rtl/etl_classify.sv =====
// Character classifier of the expression tokenizer.
// Depends on etl_pkg for character constants and char_class_t.
module etl_classify (
  input  logic [7:0]          ch,
  output etl_pkg::char_class_t cls
);
  import etl_pkg::*;

  always_comb begin
    cls.digit  = (ch >= 8'h30) && (ch <= 8'h39);
    cls.alpha  = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
    cls.under  = (ch == CH_UNDER);
    cls.space  = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    cls.oper   = (ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_SLASH) ||
                 (ch == CH_BSLASH) || (ch == CH_STAR) || (ch == CH_CARET) ||
                 (ch == CH_EQUAL) || (ch == CH_GREAT) || (ch == CH_LESS) ||
                 (ch == CH_COLON);
    cls.lparen = (ch == CH_LPAREN);
    cls.rparen = (ch == CH_RPAREN);
    cls.comma  = (ch == CH_COMMA);
    cls.dot    = (ch == CH_DOT);
    cls.exp    = (ch == CH_E_LO) || (ch == CH_E_UP);
    cls.minus  = (ch == CH_MINUS);
  end

endmodule

// ===== rtl/etl_lexer.sv =====
// Scan state and token formation of the expression tokenizer.
// Depends on etl_pkg and etl_classify; emits up to two tokens per word.
module etl_lexer #(
  parameter int POSITION_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic [7:0]      ch,
  input  logic            end_marker,
  output logic [1:0]      push_n,
  output etl_pkg::token_t tok_a,
  output etl_pkg::token_t tok_b
);
  import etl_pkg::*;

  localparam int PW = (POSITION_BITS > 16) ? POSITION_BITS : 16;

  logic [2:0]               mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] open_start_r, open_start_nxt;
  logic [7:0]               open_sym_r, open_sym_nxt;

  char_class_t              cls;
  logic [2:0]               cont_mode;
  logic                     open_tok;
  logic                     cont;
  logic [POSITION_BITS-1:0] pos_inc;
  logic [POSITION_BITS-1:0] len_raw;
  logic [15:0]              pos_sat, start_sat, len_sat;
  token_t                   close_tok, own_tok;
  logic                     own_valid;

  function automatic logic [15:0] sat16(input logic [POSITION_BITS-1:0] v);
    logic [PW-1:0] ext;
    ext = PW'(v);
    sat16 = (ext > PW'(17'h0FFFF)) ? 16'hFFFF : ext[15:0];
  endfunction

  etl_classify u_classify (
    .ch  (ch),
    .cls (cls)
  );

  assign open_tok = (mode_r >= MODE_IDENT) && (mode_r <= MODE_EXP_DIGITS);
  assign pos_inc  = (pos_r != {POSITION_BITS{1'b1}}) ? pos_r + 1'b1 : pos_r;
  assign len_raw  = pos_r - open_start_r;
  assign pos_sat   = sat16(pos_r);
  assign start_sat = sat16(open_start_r);
  assign len_sat   = sat16(len_raw);

  always_comb begin
    unique case (mode_r)
      MODE_IDENT:      cont_mode = (cls.alpha || cls.digit || cls.under) ? MODE_IDENT
                                                                         : MODE_IDLE;
      MODE_INT:        cont_mode = cls.digit ? MODE_INT :
                                   cls.dot ? MODE_FRAC :
                                   cls.exp ? MODE_EXP_START : MODE_IDLE;
      MODE_FRAC:       cont_mode = cls.digit ? MODE_FRAC :
                                   cls.exp ? MODE_EXP_START : MODE_IDLE;
      MODE_EXP_START:  cont_mode = (cls.digit || cls.minus) ? MODE_EXP_DIGITS : MODE_IDLE;
      MODE_EXP_DIGITS: cont_mode = cls.digit ? MODE_EXP_DIGITS : MODE_IDLE;
      default:         cont_mode = MODE_IDLE;
    endcase
  end

  assign cont = !end_marker && open_tok && (cont_mode != MODE_IDLE);

  always_comb begin
    close_tok.kind   = (mode_r == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
    close_tok.start  = start_sat;
    close_tok.length = len_sat;
    close_tok.symbol = open_sym_r;
    close_tok.last   = 1'b0;

    own_tok.start  = pos_sat;
    own_tok.length = 16'd1;
    own_tok.symbol = ch;
    own_tok.last   = 1'b1;
    own_tok.kind   = KIND_INVALID;
    own_valid      = 1'b1;

    mode_nxt       = MODE_IDLE;
    pos_nxt        = pos_inc;
    open_start_nxt = open_start_r;
    open_sym_nxt   = open_sym_r;

    priority if (cont) begin
      mode_nxt  = cont_mode;
      own_valid = 1'b0;
    end else if (end_marker) begin
      own_tok.kind   = KIND_END;
      own_tok.length = 16'd0;
      own_tok.symbol = 8'd0;
      pos_nxt        = pos_r;
    end else if (cls.space) begin
      own_valid = 1'b0;
    end else if (cls.oper) begin
      own_tok.kind = KIND_OPERATOR;
    end else if (cls.lparen) begin
      own_tok.kind = KIND_LPAREN;
    end else if (cls.rparen) begin
      own_tok.kind = KIND_RPAREN;
    end else if (cls.comma) begin
      own_tok.kind = KIND_COMMA;
    end else if (cls.alpha || cls.under || cls.digit || cls.dot) begin
      own_valid      = 1'b0;
      mode_nxt       = cls.digit ? MODE_INT : (cls.dot ? MODE_FRAC : MODE_IDENT);
      open_start_nxt = pos_r;
      open_sym_nxt   = ch;
    end else begin
      own_tok.kind = KIND_INVALID;
    end
  end

  always_comb begin
    tok_a  = own_tok;
    tok_b  = own_tok;
    push_n = 2'd0;
    if (!cont && open_tok) begin
      tok_a = close_tok;
      if (own_valid) begin
        push_n = 2'd2;
      end else begin
        tok_a.last = 1'b1;
        push_n     = 2'd1;
      end
    end else if (own_valid) begin
      push_n = 2'd1;
    end
    if (!take) begin
      push_n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      pos_r        <= '0;
      open_start_r <= '0;
      open_sym_r   <= 8'd0;
    end else if (take) begin
      mode_r       <= mode_nxt;
      pos_r        <= pos_nxt;
      open_start_r <= open_start_nxt;
      open_sym_r   <= open_sym_nxt;
    end
  end

endmodule

// ===== rtl/etl_queue.sv =====
// Result queue of the expression tokenizer: takes up to two tokens a cycle.
// Depends on etl_pkg and the assertion macro header.
`include "expression_tokenizer_top_macros.svh"

module etl_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      push_n,
  input  etl_pkg::token_t tok_a,
  input  etl_pkg::token_t tok_b,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output etl_pkg::token_t head
);
  import etl_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  token_t        mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic [AW-1:0] wr_ptr_b;
  logic          do_pop;

  assign do_pop     = pop && (count_r != '0);
  assign wr_ptr_b   = wr_ptr_r + 1'b1;
  assign wr_ptr_nxt = wr_ptr_r + AW'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + AW'(do_pop);
  assign count_nxt  = count_r + (AW+1)'(push_n) - (AW+1)'(do_pop);
  assign full       = count_r > (AW+1)'(QUEUE_DEPTH - 2);
  assign not_empty  = count_r != '0;
  assign head       = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr_r] <= tok_a;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr_b] <= tok_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `ETL_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= (AW+1)'(QUEUE_DEPTH))
  `ETL_ASSERT_SAME(a_push_room, clk, rst_n, push_n != 2'd0, !full && push_n != 2'd3)
  `ETL_ASSERT_NEXT(a_pop_drain, clk, rst_n, do_pop && push_n == 2'd0,
                   count_r == $past(count_r) - 1'b1)
  `ETL_ASSERT_NEXT(a_last_pair, clk, rst_n, push_n == 2'd2,
                   !mem[$past(wr_ptr_r)].last && mem[$past(wr_ptr_b)].last)

endmodule

// ===== rtl/expression_tokenizer_top.sv =====
// Expression tokenizer: streaming lexer for arithmetic expression text.
// Input channel carries one character or an end marker per word; the output
// channel carries one token per word (kind, start, length, first symbol and
// a flag on the last token that a given input word produced).
// A word accepted at an edge updates the scan state at once; its tokens go
// into the result queue at that edge, one token per output word. Throughput
// is one input word per cycle while in_stall is low. A word that closes an
// open token and also yields its own token produces two output words; they
// drain at one per cycle from a four-entry queue while out_stall is low.
// in_stall is high while the queue holds more than two words, so it depends
// only on registered state; out_valid is high whenever the queue is not empty.
// When the receiver holds out_stall, the head token stays on the outputs and
// the queue fills until in_stall stops the sender.
// Reset (rst_n low, synchronous) returns the scanner to idle with position
// zero and empties the queue; no clearing pass is needed.
// Depends on etl_pkg, etl_lexer, etl_classify and etl_queue.
module expression_tokenizer_top #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_character,
  input  logic        in_end_marker,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_token_kind,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic [7:0]  out_first_symbol,
  output logic        out_last_of_run
);
  import etl_pkg::*;

  logic       take;
  logic [1:0] push_n;
  token_t     tok_a, tok_b, head;
  logic       full;

  assign in_stall = full;
  assign take     = in_valid && !full;

  etl_lexer #(
    .POSITION_BITS (POSITION_BITS)
  ) u_lexer (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .ch         (in_character),
    .end_marker (in_end_marker),
    .push_n     (push_n),
    .tok_a      (tok_a),
    .tok_b      (tok_b)
  );

  etl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .tok_a     (tok_a),
    .tok_b     (tok_b),
    .pop       (!out_stall),
    .full      (full),
    .not_empty (out_valid),
    .head      (head)
  );

  assign out_token_kind   = head.kind;
  assign out_token_start  = head.start;
  assign out_token_length = head.length;
  assign out_first_symbol = head.symbol;
  assign out_last_of_run  = head.last;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for expression_tokenizer_top: streams characters and end markers
// through the lexer and predicts every token in the testbench itself.
// Depends on etl_pkg and the RTL of expression_tokenizer_top.
`timescale 1ns / 100ps

module testbench;
  import etl_pkg::*;

  localparam int POS_BITS    = 16;
  localparam int CYCLE_LIMIT = 50_000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_WORDS = 390;
  localparam int SAT_RUN     = 24;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
    logic       burst;
  } text_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_character = 8'h00;
  logic        in_end_marker = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_token_kind;
  logic [15:0] out_token_start;
  logic [15:0] out_token_length;
  logic [7:0]  out_first_symbol;
  logic        out_last_of_run;

  text_word_t char_feed[$];
  token_t     awaited_tokens[$];

  logic [2:0]  scan_mode = MODE_IDLE;
  logic [15:0] scan_pos = '0;
  logic [15:0] open_start = '0;
  logic [7:0]  open_symbol = '0;

  int mismatches = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int received_count = 0;

  expression_tokenizer_top #(.POSITION_BITS(POS_BITS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_character     (in_character),
    .in_end_marker    (in_end_marker),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_first_symbol (out_first_symbol),
    .out_last_of_run  (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_ident_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || is_digit(c) ||
           c == CH_UNDER;
  endfunction

  function automatic bit mode_is_open(logic [2:0] m);
    return m >= MODE_IDENT && m <= MODE_EXP_DIGITS;
  endfunction

  function automatic token_t make_token(logic [2:0] kind, logic [15:0] start,
                                        logic [15:0] len, logic [7:0] sym);
    token_t t;
    t.kind   = kind;
    t.start  = start;
    t.length = len;
    t.symbol = sym;
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] ident_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return "a" + 8'(r);
    if (r < 52) return "A" + 8'(r - 26);
    if (r < 62) return "0" + 8'(r - 52);
    return CH_UNDER;
  endfunction

  // advance the lexer copy by one word and queue the tokens it yields
  task automatic lex_step(input logic [7:0] c, input logic fin);
    token_t      made[$];
    logic [2:0]  cont;
    logic [2:0]  kind;
    logic [15:0] here;
    here = scan_pos;
    cont = MODE_IDLE;
    if (!fin) begin
      case (scan_mode)
        MODE_IDENT: cont = is_ident_char(c) ? MODE_IDENT : MODE_IDLE;
        MODE_INT: begin
          if (is_digit(c)) cont = MODE_INT;
          else if (c == CH_DOT) cont = MODE_FRAC;
          else if (c == CH_E_LO || c == CH_E_UP) cont = MODE_EXP_START;
        end
        MODE_FRAC: begin
          if (is_digit(c)) cont = MODE_FRAC;
          else if (c == CH_E_LO || c == CH_E_UP) cont = MODE_EXP_START;
        end
        MODE_EXP_START: cont = (is_digit(c) || c == CH_MINUS) ? MODE_EXP_DIGITS : MODE_IDLE;
        MODE_EXP_DIGITS: cont = is_digit(c) ? MODE_EXP_DIGITS : MODE_IDLE;
        default: cont = MODE_IDLE;
      endcase
    end
    if (cont != MODE_IDLE) begin
      scan_mode = cont;
    end else begin
      if (mode_is_open(scan_mode))
        made.push_back(make_token(scan_mode == MODE_IDENT ? KIND_IDENT : KIND_NUMBER,
                                  open_start, here - open_start, open_symbol));
      scan_mode = MODE_IDLE;
      if (fin) begin
        made.push_back(make_token(KIND_END, here, 16'd0, 8'd0));
      end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      end else if (is_ident_char(c) || c == CH_DOT) begin
        scan_mode   = is_digit(c) ? MODE_INT : (c == CH_DOT ? MODE_FRAC : MODE_IDENT);
        open_start  = here;
        open_symbol = c;
      end else begin
        case (c)
          CH_PLUS, CH_MINUS, CH_SLASH, CH_BSLASH, CH_STAR, CH_CARET, CH_EQUAL,
          CH_GREAT, CH_LESS, CH_COLON: kind = KIND_OPERATOR;
          CH_LPAREN: kind = KIND_LPAREN;
          CH_RPAREN: kind = KIND_RPAREN;
          CH_COMMA: kind = KIND_COMMA;
          default: kind = KIND_INVALID;
        endcase
        made.push_back(make_token(kind, here, 16'd1, c));
      end
    end
    if (!fin && scan_pos != '1) scan_pos = scan_pos + 16'd1;
    if (made.size() > 0) made[made.size() - 1].last = 1'b1;
    foreach (made[i]) awaited_tokens.push_back(made[i]);
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("token %0d %s got 0x%0h expected 0x%0h",
                                received_count, name, got, want));
  endtask

  task automatic feed(input logic [7:0] c, input logic fin, input logic burst);
    text_word_t w;
    w.ch    = c;
    w.fin   = fin;
    w.burst = burst;
    char_feed.push_back(w);
  endtask

  // driver: hold a stalled word, otherwise present the next one after its gap
  always @(posedge clk) begin
    text_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) lex_step(in_character, in_end_marker);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (char_feed.size() > 0) begin
          w = char_feed.pop_front();
          in_valid      <= 1'b1;
          in_character  <= w.ch;
          in_end_marker <= w.fin;
          send_gap = w.burst ? 0 : draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each accepted token, then pick the next stall value
  always @(posedge clk) begin
    token_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_tokens.size() == 0) begin
          report_mismatch($sformatf("token %0d arrived with none expected", received_count));
        end else begin
          want = awaited_tokens.pop_front();
          check_field("kind", 16'(out_token_kind), 16'(want.kind));
          check_field("start", out_token_start, want.start);
          check_field("length", out_token_length, want.length);
          check_field("symbol", 16'(out_first_symbol), 16'(want.symbol));
          check_field("last", 16'(out_last_of_run), 16'(want.last));
        end
        received_count++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && received_count >= 60) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ((received_count / 100) % 4 == 3) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = ($urandom_range(0, 99) < 25) ? draw_gap() : 0;
        out_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** expression_tokenizer_top: FAILED **");
      $finish;
    end
  end

  initial begin
    int         pick;
    int         n;
    int         total;
    logic       burst;
    logic [7:0] c;
    // invalid at idle, identifier closed by a high code, and a paren
    feed(8'h00, 1'b0, 1'b0);
    feed(CH_UNDER, 1'b0, 1'b0);
    feed("Z", 1'b0, 1'b0);
    feed("9", 1'b0, 1'b0);
    feed(8'hFF, 1'b0, 1'b0);
    feed(CH_LPAREN, 1'b0, 1'b0);
    // number with fraction and signed exponent, closed by a second e
    feed("1", 1'b0, 1'b0);
    feed(CH_DOT, 1'b0, 1'b0);
    feed("5", 1'b0, 1'b0);
    feed(CH_E_LO, 1'b0, 1'b0);
    feed(CH_MINUS, 1'b0, 1'b0);
    feed("3", 1'b0, 1'b0);
    feed(CH_E_LO, 1'b0, 1'b0);
    feed(CH_COMMA, 1'b0, 1'b0);
    // second dot, bare exponent closed by a paren, e after e
    feed(CH_DOT, 1'b0, 1'b0);
    feed(CH_DOT, 1'b0, 1'b0);
    feed(CH_E_UP, 1'b0, 1'b0);
    feed(CH_RPAREN, 1'b0, 1'b0);
    feed(CH_TAB, 1'b0, 1'b0);
    feed("7", 1'b0, 1'b0);
    feed(CH_E_UP, 1'b0, 1'b0);
    feed(CH_E_UP, 1'b0, 1'b0);
    feed(CH_MINUS, 1'b0, 1'b0);
    // end marker when idle and with an open token
    feed(8'hFF, 1'b1, 1'b0);
    feed("x", 1'b0, 1'b0);
    feed(8'h00, 1'b1, 1'b0);

    total = char_feed.size() + RANDOM_WORDS;
    while (char_feed.size() < total) begin
      burst = ((char_feed.size() / 64) % 3 == 1);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        feed(($urandom_range(0, 9) == 0) ? CH_UNDER : "a" + 8'($urandom_range(0, 25)),
             1'b0, burst);
        n = $urandom_range(0, 6);
        repeat (n) feed(ident_char(), 1'b0, burst);
      end else if (pick < 55) begin
        if ($urandom_range(0, 9) == 0) begin
          feed(CH_DOT, 1'b0, burst);
        end else begin
          feed("0" + 8'($urandom_range(0, 9)), 1'b0, burst);
          n = $urandom_range(0, 4);
          repeat (n) feed("0" + 8'($urandom_range(0, 9)), 1'b0, burst);
          if ($urandom_range(0, 9) < 4) feed(CH_DOT, 1'b0, burst);
        end
        n = $urandom_range(0, 3);
        repeat (n) feed("0" + 8'($urandom_range(0, 9)), 1'b0, burst);
        if ($urandom_range(0, 99) < 35) begin
          feed($urandom_range(0, 1) ? CH_E_LO : CH_E_UP, 1'b0, burst);
          if ($urandom_range(0, 1)) feed(CH_MINUS, 1'b0, burst);
          n = $urandom_range(0, 3);
          repeat (n) feed("0" + 8'($urandom_range(0, 9)), 1'b0, burst);
        end
      end else if (pick < 70) begin
        case ($urandom_range(0, 9))
          0: c = CH_PLUS;
          1: c = CH_MINUS;
          2: c = CH_SLASH;
          3: c = CH_BSLASH;
          4: c = CH_STAR;
          5: c = CH_CARET;
          6: c = CH_EQUAL;
          7: c = CH_GREAT;
          8: c = CH_LESS;
          default: c = CH_COLON;
        endcase
        feed(c, 1'b0, burst);
      end else if (pick < 78) begin
        case ($urandom_range(0, 2))
          0: c = CH_LPAREN;
          1: c = CH_RPAREN;
          default: c = CH_COMMA;
        endcase
        feed(c, 1'b0, burst);
      end else if (pick < 88) begin
        n = $urandom_range(0, 6);
        feed((n == 6) ? CH_SPACE : CH_TAB + 8'(n % 5), 1'b0, burst);
      end else if (pick < 96) begin
        feed(8'($urandom_range(0, 255)), 1'b0, burst);
      end else begin
        feed(8'($urandom_range(0, 255)), 1'b1, burst);
      end
    end

    // send a long identifier back to back, close it with an operator, then send two runs that end in end markers
    feed("q", 1'b0, 1'b1);
    repeat (SAT_RUN) feed(ident_char(), 1'b0, 1'b1);
    feed(CH_PLUS, 1'b0, 1'b1);
    feed("4", 1'b0, 1'b1);
    feed(8'h00, 1'b1, 1'b1);
    feed(CH_LPAREN, 1'b0, 1'b0);
    feed(8'h80, 1'b0, 1'b0);
    feed(8'h00, 1'b1, 1'b0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (char_feed.size() != 0 || in_valid || awaited_tokens.size() != 0);
    repeat (16) @(negedge clk);
    if (awaited_tokens.size() != 0)
      report_mismatch($sformatf("%0d tokens never arrived", awaited_tokens.size()));
    if (mismatches == 0) begin
      $display("** expression_tokenizer_top: PASSED **");
    end else begin
      $display("** expression_tokenizer_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== expression_tokenizer_top.f =====
+incdir+rtl
rtl/etl_pkg.sv
rtl/etl_classify.sv
rtl/etl_lexer.sv
rtl/etl_queue.sv
rtl/expression_tokenizer_top.sv
sim/testbench.sv
